// ===== rtl/core/i64alu_pkg.sv =====
// Shared types and constants for the 64-bit integer ALU with power
package i64alu_pkg;
  localparam int DataWidth = 64;
  typedef logic [DataWidth-1:0] word_t;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2,
    OP_DIV = 3'd3, OP_MOD = 3'd4, OP_POW = 3'd5
  } op_t;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_NEGEXP = 2'd2
  } status_t;
  localparam int ExpBits = $clog2(DataWidth);
  localparam int HalfW = DataWidth / 2;
endpackage

// ===== rtl/core/i64alu_mul.sv =====
// Multi-cycle 64x64 wrapping multiplier built from 32x32 partial products
module i64alu_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  i64alu_pkg::word_t   a,
  input  i64alu_pkg::word_t   b,
  output logic                done,
  output i64alu_pkg::word_t   p
);
  import i64alu_pkg::*;

  logic [1:0] step_r, step_nxt;
  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  word_t      a_r, b_r, acc_r, acc_nxt;
  logic [HalfW-1:0] x, y;
  word_t      pp_r;

  always_comb begin
    unique case (step_r)
      2'd0:    begin x = a_r[HalfW-1:0];         y = b_r[HalfW-1:0];         end
      2'd1:    begin x = a_r[DataWidth-1:HalfW]; y = b_r[HalfW-1:0];         end
      default: begin x = a_r[HalfW-1:0];         y = b_r[DataWidth-1:HalfW]; end
    endcase
  end

  always_ff @(posedge clk) begin
    pp_r <= word_t'(x) * word_t'(y);
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd1) acc_nxt = pp_r;
      else if (step_r != 2'd0) acc_nxt = acc_r + (pp_r << HalfW);
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule

// ===== rtl/core/int64_alu_with_power.sv =====
// Top level: sequenced 64-bit integer ALU with add, sub, mul, div, mod and power
//
// Input channel in_valid/in_stall carries in_req_type, in_lhs and in_rhs; a beat
// is taken when in_valid is high and in_stall low. The result channel
// out_valid/out_stall carries out_value and out_status, held until taken.
// One item is in flight at a time; in_stall is high from acceptance until the
// result beat is taken.
// Add, sub, division by zero, unused codes and trivial or negative power go
// straight to the result beat; mul runs four partial-product steps of the
// shared multiplier plus the capture; div and mod run 64 restoring division
// steps, one a cycle, then the sign fix; power runs a chain of shared
// multiplies, at most 11 multiplies for exponent 63. After the result beat
// the block returns to idle before it takes the next item.
// Reset (rst_n low, synchronous) empties the block; out_valid drops.
// While out_stall is high the result holds and no new item is taken.
module int64_alu_with_power (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_req_type,
  input  logic signed [63:0]  in_lhs,
  input  logic signed [63:0]  in_rhs,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [63:0]  out_value,
  output logic [1:0]          out_status
);
  import i64alu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_PSQ, S_PMUL, S_PBASE, S_OUT
  } state_t;

  state_t state_r;
  logic [2:0] op_r;
  word_t b_r, res_r, acc_r, base_r, quo_r;
  logic [DataWidth:0] rem_r;
  logic [ExpBits-1:0] e_r;
  logic [ExpBits:0] cnt_r;
  logic [1:0] st_r;
  logic neg_r;

  logic  m_start;
  word_t m_a, m_b, m_p;
  logic  m_done;

  i64alu_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start),
    .a(m_a), .b(m_b), .done(m_done), .p(m_p)
  );

  logic  take;
  word_t lhs, rhs, mag_a, mag_b;
  logic [DataWidth:0] trial;
  assign take  = (state_r == S_IDLE) && in_valid;
  assign lhs   = word_t'(in_lhs);
  assign rhs   = word_t'(in_rhs);
  assign mag_a = lhs[DataWidth-1] ? (~lhs + word_t'(1)) : lhs;
  assign mag_b = rhs[DataWidth-1] ? (~rhs + word_t'(1)) : rhs;
  assign trial = {rem_r[DataWidth-1:0], quo_r[DataWidth-1]} - {1'b0, b_r};

  always_comb begin
    m_start = 1'b0;
    m_a = base_r;
    m_b = base_r;
    if (take && in_req_type == OP_MUL) begin
      m_start = 1'b1; m_a = lhs; m_b = rhs;
    end else if (state_r == S_PSQ && e_r != '0) begin
      m_start = 1'b1;
      if (e_r[0]) m_a = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_req_type;
          unique case (in_req_type)
            OP_ADD: begin
              res_r <= lhs + rhs; st_r <= ST_OK; state_r <= S_OUT;
            end
            OP_SUB: begin
              res_r <= lhs - rhs; st_r <= ST_OK; state_r <= S_OUT;
            end
            OP_MUL: begin
              st_r <= ST_OK; state_r <= S_MUL;
            end
            OP_DIV, OP_MOD: begin
              if (rhs == '0) begin
                res_r <= '0; st_r <= ST_DIV0; state_r <= S_OUT;
              end else begin
                quo_r <= mag_a; b_r <= mag_b; rem_r <= '0;
                cnt_r <= '0;
                st_r <= ST_OK;
                neg_r <= (in_req_type == OP_DIV) ?
                         (lhs[DataWidth-1] ^ rhs[DataWidth-1]) : lhs[DataWidth-1];
                state_r <= S_DIV;
              end
            end
            OP_POW: begin
              if (rhs[DataWidth-1]) begin
                res_r <= lhs; st_r <= ST_NEGEXP; state_r <= S_OUT;
              end else if (rhs == '0) begin
                res_r <= word_t'(1); st_r <= ST_OK; state_r <= S_OUT;
              end else if (rhs >= word_t'(DataWidth)) begin
                if (lhs == word_t'(1)) res_r <= word_t'(1);
                else if (lhs == '1) res_r <= rhs[0] ? '1 : word_t'(1);
                else res_r <= '0;
                st_r <= ST_OK;
                state_r <= S_OUT;
              end else begin
                acc_r <= word_t'(1); base_r <= lhs;
                e_r <= rhs[ExpBits-1:0];
                st_r <= ST_OK;
                state_r <= S_PSQ;
              end
            end
            default: begin
              res_r <= lhs; st_r <= ST_OK; state_r <= S_OUT;
            end
          endcase
        end
        S_MUL: if (m_done) begin
          res_r <= m_p; state_r <= S_OUT;
        end
        S_DIV: begin
          if (cnt_r == (ExpBits+1)'(DataWidth)) begin
            if (op_r == OP_DIV) res_r <= neg_r ? (~quo_r + word_t'(1)) : quo_r;
            else res_r <= neg_r ? (~rem_r[DataWidth-1:0] + word_t'(1))
                                : rem_r[DataWidth-1:0];
            state_r <= S_OUT;
          end else begin
            quo_r <= {quo_r[DataWidth-2:0], ~trial[DataWidth]};
            rem_r <= trial[DataWidth] ? {rem_r[DataWidth-1:0], quo_r[DataWidth-1]} : trial;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_PSQ: begin
          if (e_r == '0) begin
            res_r <= acc_r; state_r <= S_OUT;
          end else if (e_r[0]) begin
            state_r <= S_PMUL;
          end else begin
            state_r <= S_PBASE;
          end
        end
        S_PMUL: if (m_done) begin
          acc_r <= m_p;
          e_r <= {e_r[ExpBits-1:1], 1'b0};
          state_r <= S_PSQ;
        end
        S_PBASE: if (m_done) begin
          base_r <= m_p;
          e_r <= e_r >> 1;
          state_r <= S_PSQ;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign out_value  = res_r;
  assign out_status = st_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_status));
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall);
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_DIV0) ||
                  (out_status == ST_NEGEXP));
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid);
endmodule
